>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at every clock edge outside reset
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// check at every clock edge, reset included
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

>>> rtl/ced_pkg.sv
// Types, codes and helper functions of the escape sequence decoder.
// Used by the decoder, the queue and the top level; depends on nothing.
package ced_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_HEX   = 2'd2;
  localparam logic [1:0] PH_NUM   = 2'd3;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X    = 8'h78;

  localparam logic [2:0] REG_OCTAL_MODE = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]     cnt;
    res_t [1:0]     res;
  } step_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61) begin
      v = b - 8'h57;
    end else begin
      v = b - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic is_num(input logic [7:0] b, input logic octal);
    return (b >= 8'h30) && (b <= (octal ? 8'h37 : 8'h39));
  endfunction

  function automatic logic [7:0] letter_code(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'h65:   r = 8'h1B;
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ced_decoder.sv
// Parse state and per-item decode: turns one input byte into up to two results.
// Depends on ced_pkg.
module ced_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  logic           octal_i,
  output ced_pkg::step_t step_o
);
  import ced_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [7:0] val_q, val_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    logic       handled;
    logic [1:0] n;
    res_t [1:0] res;
    logic [7:0] acc;
    handled = 1'b0;
    n       = 2'd0;
    res     = '0;
    phase_d = phase_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    acc     = '0;
    unique case (phase_q)
      PH_ESC: begin
        handled = 1'b1;
        if (byte_i == CHAR_X) begin
          phase_d = PH_HEX;
          val_d   = '0;
          cnt_d   = 2'd0;
        end else if (is_num(byte_i, octal_i)) begin
          phase_d = PH_NUM;
          val_d   = {4'd0, byte_i[3:0]};
          cnt_d   = 2'd1;
        end else begin
          res[n[0]] = '{data: letter_code(byte_i), has: 1'b1, last: 1'b0};
          n         = n + 2'd1;
          phase_d   = PH_PLAIN;
          val_d     = '0;
          cnt_d     = 2'd0;
        end
      end
      PH_HEX: begin
        if (is_hex(byte_i) && cnt_q < 2'd2) begin
          handled = 1'b1;
          val_d   = {val_q[3:0], hex_val(byte_i)};
          cnt_d   = cnt_q + 2'd1;
          if (cnt_d >= 2'd2) begin
            res[n[0]] = '{data: val_d, has: 1'b1, last: 1'b0};
            n         = n + 2'd1;
            phase_d   = PH_PLAIN;
            val_d     = '0;
            cnt_d     = 2'd0;
          end
        end else begin
          res[n[0]] = '{data: val_q, has: 1'b1, last: 1'b0};
          n         = n + 2'd1;
          phase_d   = PH_PLAIN;
          val_d     = '0;
          cnt_d     = 2'd0;
        end
      end
      PH_NUM: begin
        if (is_num(byte_i, octal_i) && cnt_q < 2'd3) begin
          handled = 1'b1;
          acc     = octal_i ? {val_q[4:0], 3'd0}
                            : ({val_q[4:0], 3'd0} + {val_q[6:0], 1'b0});
          val_d   = acc + {4'd0, byte_i[3:0]};
          cnt_d   = cnt_q + 2'd1;
          if (cnt_d == 2'd3) begin
            res[n[0]] = '{data: val_d, has: 1'b1, last: 1'b0};
            n         = n + 2'd1;
            phase_d   = PH_PLAIN;
            val_d     = '0;
            cnt_d     = 2'd0;
          end
        end else begin
          res[n[0]] = '{data: val_q, has: 1'b1, last: 1'b0};
          n         = n + 2'd1;
          phase_d   = PH_PLAIN;
          val_d     = '0;
          cnt_d     = 2'd0;
        end
      end
      default: ;
    endcase

    if (!handled) begin
      if (byte_i == BACKSLASH) begin
        phase_d = PH_ESC;
      end else begin
        res[n[0]] = '{data: byte_i, has: 1'b1, last: 1'b0};
        n         = n + 2'd1;
      end
    end

    if (last_i) begin
      if (phase_d == PH_HEX || phase_d == PH_NUM) begin
        res[n[0]] = '{data: val_d, has: 1'b1, last: 1'b0};
        n         = n + 2'd1;
      end
      phase_d = PH_PLAIN;
      val_d   = '0;
      cnt_d   = 2'd0;
      if (n == 2'd0) begin
        res[0] = '{data: 8'h00, has: 1'b0, last: 1'b0};
        n      = 2'd1;
      end
      res[n[1]].last = 1'b1;
    end

    step_o.cnt = n;
    step_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      val_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/ced_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
// Depends on ced_pkg.
module ced_fifo #(
  parameter int unsigned Depth = ced_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ced_pkg::step_t step_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output ced_pkg::res_t  res_o
);
  import ced_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr_nx, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;

  assign wr_nx   = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
  assign push_n  = push_i ? step_i.cnt : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_q <= RoomMax);
  assign res_o   = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    if (push_n == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_n == 2'd2) begin
      wr_d = (wr_nx == PtrLast) ? '0 : wr_nx + PtrW'(1);
    end
    rd_d = rd_q;
    if (pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= step_i.res[0];
    end
    if (push_n == 2'd2) begin
      mem_q[wr_nx] <= step_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/c_escape_sequence_decoder.sv
// Top level of the C escape sequence decoder: config register, decoder, result queue.
// Depends on ced_pkg, ced_decoder and ced_fifo.
//
//   port group   direction   handshake
//   in_*         input       in_valid_i / in_ready_o
//   out_*        output      out_valid_o / out_ready_i
//   APB          config      psel & penable & pwrite, pready tied high
//
// An item is decoded in the cycle it is accepted; its results enter the queue at that edge
// and the first is shown from the queue once any older results have been taken.
// One item per cycle while the queue holds at most Depth-2 results; the single output port
// drains one result per cycle while out_ready_i is high; two-result items are paced by it.
// Reset clears parse state, the queue and octal_mode.
module c_escape_sequence_decoder #(
  parameter int unsigned FifoDepth = ced_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        out_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ced_pkg::*;

  logic  octal_q;
  logic  fire;
  step_t step;
  res_t  res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OCTAL_MODE[0]) ? {31'd0, octal_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octal_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_OCTAL_MODE[0]) begin
      octal_q <= pwdata[0];
    end
  end

  assign fire = in_valid_i && in_ready_o;

  ced_decoder u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .octal_i (octal_q),
    .step_o  (step)
  );

  ced_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .step_i  (step),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res)
  );

  assign out_byte_o = res.data;
  assign has_byte_o = res.has;
  assign out_last_o = res.last;

endmodule

>>> rtl/ced_checker.sv
// Port-level checks of the escape sequence decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ced_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       out_last_o,
  input logic       pready
);

  `ASSERT_CLK(out_hold_a, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_ALWAYS(rst_idle_a, !rst_ni |-> !out_valid_o && in_ready_o)
  `ASSERT_CLK(empty_res_a, out_valid_o && !has_byte_o |-> out_last_o && out_byte_o == 8'h00)
  `ASSERT_CLK(stall_full_a, !in_ready_o |-> out_valid_o)
  `ASSERT_ALWAYS(pready_a, pready)

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (.*);
